### src/bta_pkg.sv
// ============================================================================
// bta_pkg: shared types and constants of the boundary-tag heap allocator
// Request and status codes, tag layout and the tag builder.
// ============================================================================
`default_nettype none

package bta_pkg;

    localparam int TAG_W  = 64;
    localparam int SIZE_W = 12;

    localparam logic [TAG_W-1:0] TAG_ALLOC = 64'h8000_0000_0000_0000;
    localparam logic [TAG_W-1:0] TAG_SIZE  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef logic [1:0] req_type_t;
    localparam req_type_t REQ_ALLOC  = 2'd0;
    localparam req_type_t REQ_FREE   = 2'd1;
    localparam req_type_t REQ_REINIT = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NO_FIT   = 2'd1;
    localparam status_t ST_BAD_FREE = 2'd2;

    // Tag word: allocated flag in the top bit, payload size in the low bits.
    function automatic logic [TAG_W-1:0] make_tag(input logic [SIZE_W-1:0] size,
                                                  input logic alloc);
        logic [TAG_W-1:0] t;
        t = {{(TAG_W-SIZE_W){1'b0}}, size} & TAG_SIZE;
        if (alloc) begin
            t = t | TAG_ALLOC;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### src/bta_ram.sv
// ============================================================================
// bta_ram: heap word store
// Single-port synchronous memory with a registered read.
// ============================================================================
`default_nettype none

module bta_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire                        aclk,
    input  wire                        we,
    input  wire                        re,
    input  wire  [AW-1:0]              addr,
    input  wire  [bta_pkg::TAG_W-1:0]  wdata,
    output logic [bta_pkg::TAG_W-1:0]  rdata
);

    logic [bta_pkg::TAG_W-1:0] mem [DEPTH];
    logic [bta_pkg::TAG_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/boundary_tag_first_fit_allocator_top.sv
// ============================================================================
// boundary_tag_first_fit_allocator_top: first-fit heap allocator
// An allocate or free walks the heap block by block, writes tag pairs and
// zero-fills payload words when asked. An allocate may also split its block,
// and a free checks its predecessor and successor for a merge. A failed
// request ends after its walk. A reinitialize rewrites one free block's tags.
// Throughput is one request at a time; the single port of the tag store sets it.
// After reset the block writes the initial free block's tags before it takes
// a beat. Payload words are never read back, so the store is not swept on
// reset or reinitialize; only the tags are written.
// ============================================================================
`default_nettype none

module boundary_tag_first_fit_allocator_top #(
    parameter int HEAP_WORDS = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Request stream.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // req_size[11:0], req_addr[23:12], zero_fill[24]
    input  wire  [1:0]  s_tuser,   // req_type[1:0]
    // Result stream.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // address[11:0], block_size[23:12],
                                   // free_total[35:24], blocks_now[47:36]
    output logic [1:0]  m_tuser,   // status[1:0]
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(HEAP_WORDS);
    // Position width: holds a position plus a full block size with headroom.
    localparam int PW = ((AW > bta_pkg::SIZE_W) ? AW : bta_pkg::SIZE_W) + 2;
    localparam logic [PW-1:0] LIVE_MAX = PW'(HEAP_WORDS - 2);
    localparam logic [PW-1:0] LIVE_MIN = PW'(2);
    localparam logic [PW-1:0] TWO      = PW'(2);
    localparam logic [PW-1:0] ONE      = PW'(1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_WALK_RD, S_WALK_CHK, S_SPLIT, S_TAG_H, S_TAG_F,
        S_ZSTART, S_ZERO, S_ZEND, S_PRED_RD, S_PRED_CHK, S_SUCC_RD,
        S_SUCC_CHK, S_DONE
    } state_t;

    state_t state_reg, ret_reg;

    logic [11:0]              heap_words_reg;
    logic [11:0]              live_reg;
    logic [11:0]              count_reg;
    logic [11:0]              free_reg;
    bta_pkg::req_type_t       op_reg;
    logic [11:0]              size_reg;
    logic [11:0]              addr_reg;
    logic                     zf_reg;
    logic [PW-1:0]            pos_reg;
    logic [PW-1:0]            hdr_reg;
    logic [PW-1:0]            msz_reg;
    logic [PW-1:0]            tag_pos_reg;
    logic [11:0]              tag_size_reg;
    logic                     tag_alloc_reg;
    logic [PW-1:0]            zptr_reg;
    logic [11:0]              zcnt_reg;
    bta_pkg::status_t         res_status_reg;
    logic [11:0]              res_addr_reg;
    logic [11:0]              res_size_reg;
    logic                     m_tvalid_reg;
    logic [47:0]              m_tdata_reg;
    bta_pkg::status_t         m_tuser_reg;

    // Memory port.
    logic                     ram_we, ram_re;
    logic [PW-1:0]            ram_pos;
    logic [bta_pkg::TAG_W-1:0] ram_wdata, ram_rdata;

    // Values decoded from the tag that the memory returned.
    logic [PW-1:0] rd_size, walk_end, total, live_clamp, hw_ext, nxt;
    logic          rd_alloc, cfg_write, split;
    logic [11:0]   grant;

    assign hw_ext   = PW'(heap_words_reg);
    assign live_clamp = (hw_ext < LIVE_MIN) ? LIVE_MIN :
                        (hw_ext > LIVE_MAX) ? LIVE_MAX : hw_ext;
    assign total    = PW'(live_reg) + TWO;
    assign rd_size  = PW'(ram_rdata[bta_pkg::SIZE_W-1:0]);
    assign rd_alloc = ram_rdata[bta_pkg::TAG_W-1];
    assign walk_end = pos_reg + rd_size + TWO;
    assign split    = rd_size >= (PW'(size_reg) + TWO);
    assign grant    = split ? size_reg : rd_size[11:0];
    assign nxt      = hdr_reg + msz_reg + TWO;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];

    // Memory port drive: one access per cycle, chosen by the sequencer state.
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_pos   = pos_reg;
        ram_wdata = '0;
        unique case (state_reg)
            S_WALK_RD: begin
                ram_re  = 1'b1;
                ram_pos = pos_reg;
            end
            S_PRED_RD: begin
                ram_re  = 1'b1;
                ram_pos = hdr_reg - ONE;
            end
            S_SUCC_RD: begin
                ram_re  = 1'b1;
                ram_pos = nxt;
            end
            S_TAG_H: begin
                ram_we    = 1'b1;
                ram_pos   = tag_pos_reg;
                ram_wdata = bta_pkg::make_tag(tag_size_reg, tag_alloc_reg);
            end
            S_TAG_F: begin
                ram_we    = 1'b1;
                ram_pos   = tag_pos_reg + PW'(tag_size_reg) + ONE;
                ram_wdata = bta_pkg::make_tag(tag_size_reg, tag_alloc_reg);
            end
            S_ZERO: begin
                ram_we  = 1'b1;
                ram_pos = zptr_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bta_ram #(
        .DEPTH (HEAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_pos[AW-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Request sequencer. Every access to an entry completes before the next
    // access is issued, so no forwarding is needed around the store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            ret_reg        <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            heap_words_reg <= 12'd4094;
        end else begin
            if (cfg_write) begin
                heap_words_reg <= pwdata[11:0];
            end
            // In the finishing state the result register is handled below.
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT: begin
                    live_reg      <= live_clamp[11:0];
                    count_reg     <= 12'd1;
                    free_reg      <= live_clamp[11:0];
                    tag_pos_reg   <= '0;
                    tag_size_reg  <= live_clamp[11:0];
                    tag_alloc_reg <= 1'b0;
                    state_reg     <= S_TAG_H;
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg         <= s_tuser;
                        size_reg       <= s_tdata[11:0];
                        addr_reg       <= s_tdata[23:12];
                        zf_reg         <= s_tdata[24];
                        pos_reg        <= '0;
                        res_status_reg <= bta_pkg::ST_OK;
                        res_addr_reg   <= '0;
                        res_size_reg   <= '0;
                        unique case (s_tuser)
                            bta_pkg::REQ_ALLOC, bta_pkg::REQ_FREE: begin
                                state_reg <= S_WALK_RD;
                            end
                            bta_pkg::REQ_REINIT: begin
                                ret_reg   <= S_DONE;
                                state_reg <= S_INIT;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WALK_RD: begin
                    if ((pos_reg + TWO <= total) &&
                        (op_reg == bta_pkg::REQ_ALLOC ||
                         pos_reg + ONE <= PW'(addr_reg))) begin
                        state_reg <= S_WALK_CHK;
                    end else begin
                        res_status_reg <= (op_reg == bta_pkg::REQ_ALLOC) ?
                                          bta_pkg::ST_NO_FIT : bta_pkg::ST_BAD_FREE;
                        state_reg <= S_DONE;
                    end
                end
                S_WALK_CHK: begin
                    if (walk_end > total) begin
                        res_status_reg <= (op_reg == bta_pkg::REQ_ALLOC) ?
                                          bta_pkg::ST_NO_FIT : bta_pkg::ST_BAD_FREE;
                        state_reg <= S_DONE;
                    end else if (op_reg == bta_pkg::REQ_ALLOC) begin
                        if (!rd_alloc && rd_size >= PW'(size_reg)) begin
                            res_addr_reg  <= 12'(pos_reg + ONE);
                            res_size_reg  <= grant;
                            msz_reg       <= rd_size;
                            tag_pos_reg   <= pos_reg;
                            tag_size_reg  <= grant;
                            tag_alloc_reg <= 1'b1;
                            state_reg     <= S_TAG_H;
                            if (split) begin
                                count_reg <= count_reg + 12'd1;
                                free_reg  <= free_reg - grant - 12'd2;
                                ret_reg   <= S_SPLIT;
                            end else begin
                                free_reg  <= free_reg - grant;
                                ret_reg   <= S_ZSTART;
                            end
                        end else begin
                            pos_reg   <= walk_end;
                            state_reg <= S_WALK_RD;
                        end
                    end else if (pos_reg + ONE == PW'(addr_reg)) begin
                        if (rd_alloc) begin
                            res_size_reg <= rd_size[11:0];
                            free_reg     <= free_reg + rd_size[11:0];
                            hdr_reg      <= pos_reg;
                            msz_reg      <= rd_size;
                            state_reg    <= S_ZSTART;
                        end else begin
                            res_status_reg <= bta_pkg::ST_BAD_FREE;
                            state_reg      <= S_DONE;
                        end
                    end else begin
                        pos_reg   <= walk_end;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_SPLIT: begin
                    // Remainder of a split block becomes a free block.
                    tag_pos_reg   <= pos_reg + PW'(res_size_reg) + TWO;
                    tag_size_reg  <= 12'(msz_reg - PW'(res_size_reg) - TWO);
                    tag_alloc_reg <= 1'b0;
                    ret_reg       <= S_ZSTART;
                    state_reg     <= S_TAG_H;
                end
                S_TAG_H: begin
                    state_reg <= S_TAG_F;
                end
                S_TAG_F: begin
                    state_reg <= ret_reg;
                end
                S_ZSTART: begin
                    zptr_reg <= pos_reg + ONE;
                    zcnt_reg <= res_size_reg;
                    if (zf_reg && res_size_reg != '0) begin
                        state_reg <= S_ZERO;
                    end else begin
                        state_reg <= S_ZEND;
                    end
                end
                S_ZERO: begin
                    zptr_reg <= zptr_reg + ONE;
                    zcnt_reg <= zcnt_reg - 12'd1;
                    if (zcnt_reg == 12'd1) begin
                        state_reg <= S_ZEND;
                    end
                end
                S_ZEND: begin
                    if (op_reg == bta_pkg::REQ_ALLOC) begin
                        state_reg <= S_DONE;
                    end else begin
                        tag_pos_reg   <= hdr_reg;
                        tag_size_reg  <= msz_reg[11:0];
                        tag_alloc_reg <= 1'b0;
                        ret_reg       <= S_PRED_RD;
                        state_reg     <= S_TAG_H;
                    end
                end
                S_PRED_RD: begin
                    state_reg <= (hdr_reg != '0) ? S_PRED_CHK : S_SUCC_RD;
                end
                S_PRED_CHK: begin
                    if (!rd_alloc && rd_size + TWO <= hdr_reg) begin
                        hdr_reg       <= hdr_reg - rd_size - TWO;
                        msz_reg       <= msz_reg + rd_size + TWO;
                        tag_pos_reg   <= hdr_reg - rd_size - TWO;
                        tag_size_reg  <= 12'(msz_reg + rd_size + TWO);
                        tag_alloc_reg <= 1'b0;
                        count_reg     <= count_reg - 12'd1;
                        free_reg      <= free_reg + 12'd2;
                        ret_reg       <= S_SUCC_RD;
                        state_reg     <= S_TAG_H;
                    end else begin
                        state_reg <= S_SUCC_RD;
                    end
                end
                S_SUCC_RD: begin
                    pos_reg   <= nxt;
                    state_reg <= (nxt + TWO <= total) ? S_SUCC_CHK : S_DONE;
                end
                S_SUCC_CHK: begin
                    if (!rd_alloc && walk_end <= total) begin
                        msz_reg       <= msz_reg + rd_size + TWO;
                        tag_pos_reg   <= hdr_reg;
                        tag_size_reg  <= 12'(msz_reg + rd_size + TWO);
                        tag_alloc_reg <= 1'b0;
                        count_reg     <= count_reg - 12'd1;
                        free_reg      <= free_reg + 12'd2;
                        ret_reg       <= S_DONE;
                        state_reg     <= S_TAG_H;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    // The result register frees up when its beat is taken.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {count_reg, free_reg, res_size_reg, res_addr_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign prdata   = {20'd0, heap_words_reg};

    // A zero-fill pass always has words left to clear.
    a_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ZERO |-> zcnt_reg != '0)
        else $error("zero-fill pass with an empty count");

    // Between requests the heap holds at least one block and no more free
    // words than the live heap size.
    a_accounting: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> (count_reg != '0 && free_reg <= live_reg))
        else $error("heap accounting out of range");

    // A finished request whose result register is free presents its result beat on the next cycle.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("result beat lost");

    // A tag check always follows the read that fetched its tag.
    a_walk_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK_CHK |-> $past(state_reg) == S_WALK_RD)
        else $error("tag check without a read");

endmodule

`default_nettype wire

### tb/boundary_tag_first_fit_allocator_top_tb.sv
// ============================================================================
// boundary_tag_first_fit_allocator_top_tb: self-checking bench for the heap
// allocator.
// The bench sends allocate, free and reinitialize requests with random gaps
// and random result back-pressure. A scoreboard holds its own copy of the
// tag store and the counters, and predicts every result beat. The bench
// reprograms the heap size between phases, and each phase starts with a
// reinitialize request.
// ============================================================================
`default_nettype none

module boundary_tag_first_fit_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_WORDS = 4096;
    localparam logic [2:0] ADDR_HEAP_WORDS = 3'd0;
    // The package has no code for this request type. The block must ignore
    // a request that carries it.
    localparam bta_pkg::req_type_t REQ_UNUSED = 2'd3;

    typedef struct packed {
        bta_pkg::status_t status;
        logic [11:0]      address;
        logic [11:0]      block_size;
        logic [11:0]      free_total;
        logic [11:0]      blocks_now;
    } alloc_result_t;

    // ------------------------------------------------------------------------
    // Heap scoreboard: a private tag store, the counters and a queue of
    // predicted result beats. It also keeps the list of live payloads so that
    // the stimulus can free real blocks.
    // ------------------------------------------------------------------------
    class heap_scoreboard;
        logic [63:0]   store [STORE_WORDS];
        longint        heap_reg;
        longint        heap_live;
        longint        n_blocks;
        longint        n_free;
        alloc_result_t predicted [$];
        int            live_addrs [$];
        int            errors;

        function void set_tags(longint hdr, longint size, bit alloc);
            logic [63:0] tag;
            tag = (64'(size) & bta_pkg::TAG_SIZE) | (alloc ? bta_pkg::TAG_ALLOC : 64'd0);
            if (hdr < STORE_WORDS) store[hdr] = tag;
            if (hdr + size + 1 < STORE_WORDS) store[hdr + size + 1] = tag;
        endfunction

        function void wipe(longint first, longint count);
            for (longint i = 0; i < count; i++)
                if (first + i < STORE_WORDS) store[first + i] = '0;
        endfunction

        function void rebuild();
            longint sz;
            sz = heap_reg;
            if (sz < 2) sz = 2;
            if (sz > STORE_WORDS - 2) sz = STORE_WORDS - 2;
            for (int i = 0; i < STORE_WORDS; i++) store[i] = '0;
            heap_live = sz;
            set_tags(0, sz, 1'b0);
            n_blocks = 1;
            n_free = sz;
            live_addrs.delete();
        endfunction

        function void write_heap_words(logic [31:0] value);
            heap_reg = longint'(value[11:0]);
        endfunction

        function new();
            errors = 0;
            heap_reg = 4094;
            rebuild();
        endfunction

        // Called once per accepted request beat.
        function void note_request(bta_pkg::req_type_t kind, int size, int addr, bit zf);
            longint total, pos, sz, grant, hdr, msz, nxt, psz, nsz;
            bit found;
            alloc_result_t r;
            total = heap_live + 2;
            pos = 0;
            sz = 0;
            found = 0;
            r = '0;
            r.status = bta_pkg::ST_OK;
            if (kind == bta_pkg::REQ_ALLOC) begin
                while (pos + 2 <= total) begin
                    sz = longint'(store[pos] & bta_pkg::TAG_SIZE);
                    if (pos + sz + 2 > total) break;
                    if (!store[pos][63] && sz >= size) begin
                        found = 1;
                        break;
                    end
                    pos += sz + 2;
                end
                if (!found) begin
                    r.status = bta_pkg::ST_NO_FIT;
                end else begin
                    grant = sz;
                    if (sz >= size + 2) begin
                        grant = size;
                        set_tags(pos, grant, 1'b1);
                        set_tags(pos + grant + 2, sz - grant - 2, 1'b0);
                        n_blocks++;
                        n_free -= grant + 2;
                    end else begin
                        set_tags(pos, grant, 1'b1);
                        n_free -= grant;
                    end
                    if (zf) wipe(pos + 1, grant);
                    r.address = 12'(pos + 1);
                    r.block_size = 12'(grant);
                    live_addrs.push_back(int'(pos + 1));
                end
            end else if (kind == bta_pkg::REQ_FREE) begin
                while (pos + 2 <= total && pos + 1 <= addr) begin
                    sz = longint'(store[pos] & bta_pkg::TAG_SIZE);
                    if (pos + sz + 2 > total) break;
                    if (pos + 1 == addr) begin
                        found = store[pos][63];
                        break;
                    end
                    pos += sz + 2;
                end
                if (!found) begin
                    r.status = bta_pkg::ST_BAD_FREE;
                end else begin
                    hdr = pos;
                    msz = sz;
                    r.block_size = 12'(sz);
                    if (zf) wipe(pos + 1, sz);
                    set_tags(hdr, msz, 1'b0);
                    n_free += sz;
                    // Merge with a free block just below.
                    if (hdr > 0 && !store[hdr - 1][63]) begin
                        psz = longint'(store[hdr - 1] & bta_pkg::TAG_SIZE);
                        if (psz + 2 <= hdr) begin
                            hdr -= psz + 2;
                            msz += psz + 2;
                            set_tags(hdr, msz, 1'b0);
                            n_blocks--;
                            n_free += 2;
                        end
                    end
                    // Merge with a free block just above.
                    nxt = hdr + msz + 2;
                    if (nxt + 2 <= total && !store[nxt][63]) begin
                        nsz = longint'(store[nxt] & bta_pkg::TAG_SIZE);
                        if (nxt + nsz + 2 <= total) begin
                            msz += nsz + 2;
                            set_tags(hdr, msz, 1'b0);
                            n_blocks--;
                            n_free += 2;
                        end
                    end
                    foreach (live_addrs[i])
                        if (live_addrs[i] == addr) begin
                            live_addrs.delete(i);
                            break;
                        end
                end
            end else if (kind == bta_pkg::REQ_REINIT) begin
                rebuild();
            end
            r.free_total = 12'(n_free);
            r.blocks_now = 12'(n_blocks);
            predicted.push_back(r);
        endfunction

        task report(string what, logic [11:0] got, logic [11:0] want);
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        // Called once per accepted result beat.
        task check_result(alloc_result_t got);
            alloc_result_t want;
            if (predicted.size() == 0) begin
                report("result beat with nothing outstanding", 12'd1, 12'd0);
                return;
            end
            want = predicted.pop_front();
            if (got.status != want.status)
                report("status", 12'(got.status), 12'(want.status));
            if (got.address != want.address)
                report("address", got.address, want.address);
            if (got.block_size != want.block_size)
                report("block_size", got.block_size, want.block_size);
            if (got.free_total != want.free_total)
                report("free_total", got.free_total, want.free_total);
            if (got.blocks_now != want.blocks_now)
                report("blocks_now", got.blocks_now, want.blocks_now);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    boundary_tag_first_fit_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    heap_scoreboard sb = new();
    int  result_beats = 0;
    bit  sending_done = 0;
    int  heap_now = 4094;

    // ------------------------------------------------------------------------
    // Result side. Every result beat goes to the scoreboard. The ready line
    // mostly stays high, drops for short stalls now and then, and sometimes
    // drops for a long stall. Once in the run it holds off for a long
    // stretch, so that the request side backs up while beats are still
    // being offered.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result({m_tuser, m_tdata[11:0], m_tdata[23:12],
                             m_tdata[35:24], m_tdata[47:36]});
            result_beats++;
        end
    end

    initial begin
        int  stall;
        bit  held;
        held = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && result_beats > 300) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------

    // Offer one request and hold it until it is taken. The valid line is
    // left high, so that a following request can go out back to back.
    task send_request(bta_pkg::req_type_t kind, int size, int addr, bit zf);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, zf, 12'(addr), 12'(size)};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, size, addr, zf);
    endtask

    // Lower valid for a random gap: mostly none or short, sometimes long.
    task random_gap();
        int gap;
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                           : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Let every outstanding request finish before touching the register.
    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.predicted.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task write_heap_words(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_HEAP_WORDS;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.write_heap_words(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One random request. Most are allocations and frees of live blocks.
    // The rest are impossible sizes, bad or stale addresses, the unused type
    // and reinitialize.
    task random_request();
        int pick, size, addr;
        bit zf;
        pick = $urandom_range(0, 99);
        zf = (heap_now > 1000) ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 3) == 0);
        size = $urandom_range(0, (heap_now / 6 > 1) ? heap_now / 6 : 1);
        addr = $urandom_range(0, 4095);
        if (pick < 45) begin
            if ($urandom_range(0, 19) == 0) begin
                size = $urandom_range(0, 4095);
                zf = 0;
            end
            send_request(bta_pkg::REQ_ALLOC, size, addr, zf);
        end else if (pick < 85 && sb.live_addrs.size() > 0) begin
            addr = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)];
            send_request(bta_pkg::REQ_FREE, size, addr, zf);
        end else if (pick < 94) begin
            send_request(bta_pkg::REQ_FREE, size, addr, zf);
        end else if (pick < 98) begin
            send_request(REQ_UNUSED, size, addr, zf);
        end else begin
            send_request(bta_pkg::REQ_REINIT, size, addr, zf);
        end
    endtask

    // Heap sizes of the random phases, the extremes among them. Values
    // outside the legal range must be clamped by the block.
    int phase_heap [10] = '{2, 0, 4095, 37, 120, 500, 4094, 60, 255, 3};
    int phase_len  [10] = '{60, 40, 60, 300, 300, 300, 80, 300, 300, 180};

    initial begin
        int a0, a1, a2;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, on the heap size that is in force after reset.
        send_request(bta_pkg::REQ_ALLOC, 0, 0, 1'b0);        // zero-size grant, split
        a0 = 1;
        send_request(bta_pkg::REQ_ALLOC, 5, 0, 1'b1);
        a1 = 3;
        send_request(bta_pkg::REQ_ALLOC, 1, 4095, 1'b0);
        a2 = 10;
        send_request(bta_pkg::REQ_FREE, 0, a1, 1'b1);        // free between two live blocks
        send_request(bta_pkg::REQ_FREE, 0, a1, 1'b0);        // double free
        send_request(bta_pkg::REQ_FREE, 4095, 4095, 1'b0);   // address past the heap
        send_request(bta_pkg::REQ_FREE, 0, 0, 1'b0);         // address zero
        send_request(bta_pkg::REQ_FREE, 0, 2, 1'b0);         // not a payload start
        send_request(bta_pkg::REQ_ALLOC, 4094, 0, 1'b0);     // no block fits
        send_request(bta_pkg::REQ_ALLOC, 4095, 0, 1'b0);
        send_request(REQ_UNUSED, 4095, 4095, 1'b1);          // ignored request type
        send_request(bta_pkg::REQ_FREE, 0, a2, 1'b0);        // merges both neighbors
        send_request(bta_pkg::REQ_FREE, 0, a0, 1'b0);        // merges with the successor
        send_request(bta_pkg::REQ_REINIT, 0, 0, 1'b0);
        send_request(bta_pkg::REQ_ALLOC, 4094, 0, 1'b1);     // whole heap, zero-filled
        send_request(bta_pkg::REQ_ALLOC, 0, 0, 1'b0);        // nothing left
        send_request(bta_pkg::REQ_FREE, 0, 1, 1'b1);         // free with zero-fill
        send_request(bta_pkg::REQ_ALLOC, 4092, 0, 1'b0);     // leaves a zero-size block
        send_request(bta_pkg::REQ_ALLOC, 0, 0, 1'b0);        // takes that block whole
        send_request(bta_pkg::REQ_ALLOC, 1, 0, 1'b0);
        send_request(bta_pkg::REQ_FREE, 0, 4094, 1'b0);
        send_request(bta_pkg::REQ_FREE, 0, 1, 1'b0);
        send_request(bta_pkg::REQ_REINIT, 0, 0, 1'b1);

        // Random phases, each with a new heap size.
        for (int p = 0; p < 10; p++) begin
            wait_drained();
            if (p == 2) begin
                write_heap_words(32'd9);
                // The size written here must not take effect before the
                // reinitialize that follows the next write.
                send_request(bta_pkg::REQ_ALLOC, 3, 0, 1'b0);
                wait_drained();
            end
            write_heap_words(phase_heap[p]);
            heap_now = (phase_heap[p] < 2) ? 2 : (phase_heap[p] > 4094) ? 4094 : phase_heap[p];
            send_request(bta_pkg::REQ_REINIT, 0, 0, 1'b0);
            for (int i = 0; i < phase_len[p]; i++) begin
                random_gap();
                random_request();
            end
        end
        s_tvalid <= 1'b0;
        sending_done = 1;
    end

    // End of run: wait for the last result beat, then keep watching for any
    // stray beat to show up before the verdict.
    initial begin
        wait (sending_done);
        while (sb.predicted.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
src/bta_pkg.sv
src/bta_ram.sv
src/boundary_tag_first_fit_allocator_top.sv
tb/boundary_tag_first_fit_allocator_top_tb.sv
